FILE: rtl/aarm_pkg.sv
// aarm_pkg: shared types, constants and helper functions for the
// axis-angle rotation matrix block. No dependencies.
package aarm_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int WORK_FRAC    = 30;
  localparam int WIDEN_SHIFT  = WORK_FRAC - FRAC_BITS;
  localparam int REDUCE_STEPS = 5;
  localparam int ATAN_COUNT   = 24;

  localparam logic [37:0]        TWO_PI_U  = 38'd6746518852;
  localparam logic signed [34:0] TWO_PI_S  = 35'sd6746518852;
  localparam logic signed [34:0] PI_S      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_S = 35'sd1686629713;
  localparam logic signed [33:0] GAIN_W    = 34'sh026DD3B6A;

  localparam logic signed [17:0] AXIS_ONE  = 18'sd65536;
  localparam logic signed [19:0] ONE_C     = 20'sd65536;
  localparam logic signed [24:0] OUT_MAX   = 25'sd262143;
  localparam logic signed [24:0] OUT_MIN   = -25'sd262144;

  typedef logic signed [17:0] axis_t;
  typedef logic signed [33:0] cw_t;
  typedef logic signed [18:0] elem_t;

  typedef struct packed {
    cw_t   ang;
    logic  neg;
    axis_t ax;
    axis_t ay;
    axis_t az;
  } work_t;

  typedef struct packed {
    elem_t m00;
    elem_t m01;
    elem_t m02;
    elem_t m10;
    elem_t m11;
    elem_t m12;
    elem_t m20;
    elem_t m21;
    elem_t m22;
  } mat_t;

  function automatic axis_t clamp_axis(input axis_t v);
    axis_t r;
    if (v > AXIS_ONE) begin
      r = AXIS_ONE;
    end else if (v < -AXIS_ONE) begin
      r = -AXIS_ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic cw_t atan_w(input logic [4:0] i);
    cw_t r;
    case (i)
      5'd0:    r = 34'sh03243F6A8;
      5'd1:    r = 34'sh01DAC6705;
      5'd2:    r = 34'sh00FADBAFC;
      5'd3:    r = 34'sh007F56EA6;
      5'd4:    r = 34'sh003FEAB76;
      5'd5:    r = 34'sh001FFD55B;
      5'd6:    r = 34'sh000FFFAAA;
      5'd7:    r = 34'sh0007FFF55;
      5'd8:    r = 34'sh0003FFFEA;
      5'd9:    r = 34'sh0001FFFFD;
      5'd10:   r = 34'sh0000FFFFF;
      5'd11:   r = 34'sh00007FFFF;
      5'd12:   r = 34'sh00003FFFF;
      5'd13:   r = 34'sh00001FFFF;
      5'd14:   r = 34'sh00000FFFF;
      5'd15:   r = 34'sh000007FFF;
      5'd16:   r = 34'sh000003FFF;
      5'd17:   r = 34'sh000001FFF;
      5'd18:   r = 34'sh000000FFF;
      5'd19:   r = 34'sh0000007FF;
      5'd20:   r = 34'sh0000003FF;
      5'd21:   r = 34'sh0000001FF;
      5'd22:   r = 34'sh0000000FF;
      5'd23:   r = 34'sh00000007F;
      default: r = 34'sh000000000;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/aarm_fifo.sv
// aarm_fifo: small register queue with push/full and pop/empty sides.
// Depends on nothing; DEPTH must be a power of two.
module aarm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == (AW+1)'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW+1)'(DEPTH)) else $error("queue count over depth");
  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (cnt == $past(cnt) + 1'b1)) else $error("push lost");
  a_cnt_down: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (cnt == $past(cnt) - 1'b1)) else $error("pop lost");

endmodule

FILE: rtl/aarm_front.sv
// aarm_front: accepts items, clamps the axis and reduces the angle into
// [-pi/2, pi/2] with a fold flag. Depends on aarm_pkg.
module aarm_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [23:0]       angle,
  input  aarm_pkg::axis_t          axis_x,
  input  aarm_pkg::axis_t          axis_y,
  input  aarm_pkg::axis_t          axis_z,
  output logic                     out_valid,
  input  logic                     out_full,
  output aarm_pkg::work_t          out_item
);

  localparam int NS = aarm_pkg::REDUCE_STEPS;

  logic                  adv;
  logic                  vv [0:NS];
  logic                  sg [0:NS];
  logic [37:0]           rr [0:NS];
  aarm_pkg::axis_t       xa [0:NS];
  aarm_pkg::axis_t       ya [0:NS];
  aarm_pkg::axis_t       za [0:NS];

  logic                  wv;
  logic signed [34:0]    wa;
  aarm_pkg::axis_t       wx;
  aarm_pkg::axis_t       wy;
  aarm_pkg::axis_t       wz;

  logic                  fv;
  aarm_pkg::work_t       fo;

  logic [23:0]           mag;
  logic signed [34:0]    a_s;
  logic signed [34:0]    a_w;
  logic signed [34:0]    a_f;
  logic                  f_neg;

  assign adv       = !(fv && out_full);
  assign in_ready  = adv;
  assign out_valid = fv;
  assign out_item  = fo;
  assign mag       = angle[23] ? 24'(-angle) : 24'(angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (adv) begin
      vv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sg[0] <= angle[23];
      rr[0] <= {mag, {aarm_pkg::WIDEN_SHIFT{1'b0}}};
      xa[0] <= aarm_pkg::clamp_axis(axis_x);
      ya[0] <= aarm_pkg::clamp_axis(axis_y);
      za[0] <= aarm_pkg::clamp_axis(axis_z);
    end
  end

  // restoring remainder by 2*pi, one quotient bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_red
    localparam logic [37:0] SUB = aarm_pkg::TWO_PI_U << (NS - 1 - k);
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k+1] <= 1'b0;
      end else if (adv) begin
        vv[k+1] <= vv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sg[k+1] <= sg[k];
        rr[k+1] <= (rr[k] >= SUB) ? rr[k] - SUB : rr[k];
        xa[k+1] <= xa[k];
        ya[k+1] <= ya[k];
        za[k+1] <= za[k];
      end
    end
  end

  always_comb begin
    a_s = $signed({1'b0, rr[NS][33:0]});
    if (sg[NS]) begin
      a_s = -a_s;
    end
    if (a_s >= aarm_pkg::PI_S) begin
      a_w = a_s - aarm_pkg::TWO_PI_S;
    end else if (a_s < -aarm_pkg::PI_S) begin
      a_w = a_s + aarm_pkg::TWO_PI_S;
    end else begin
      a_w = a_s;
    end
  end

  always_comb begin
    if (wa > aarm_pkg::HALF_PI_S) begin
      a_f   = wa - aarm_pkg::PI_S;
      f_neg = 1'b1;
    end else if (wa < -aarm_pkg::HALF_PI_S) begin
      a_f   = wa + aarm_pkg::PI_S;
      f_neg = 1'b1;
    end else begin
      a_f   = wa;
      f_neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= 1'b0;
      fv <= 1'b0;
    end else if (adv) begin
      wv <= vv[NS];
      fv <= wv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wa     <= a_w;
      wx     <= xa[NS];
      wy     <= ya[NS];
      wz     <= za[NS];
      fo.ang <= a_f[33:0];
      fo.neg <= f_neg;
      fo.ax  <= wx;
      fo.ay  <= wy;
      fo.az  <= wz;
    end
  end

endmodule

FILE: rtl/aarm_back.sv
// aarm_back: CORDIC pipeline for cosine and sine, then the matrix products,
// rounding and saturation. Depends on aarm_pkg.
module aarm_back #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_take,
  input  aarm_pkg::work_t in_item,
  output logic            out_valid,
  input  logic            out_full,
  output aarm_pkg::mat_t  out_item
);

  localparam int S = (CORDIC_STAGES < aarm_pkg::ATAN_COUNT) ?
                     CORDIC_STAGES : aarm_pkg::ATAN_COUNT;

  logic               adv;
  logic               cv   [0:S];
  aarm_pkg::cw_t      cx   [0:S];
  aarm_pkg::cw_t      cy   [0:S];
  aarm_pkg::cw_t      cz   [0:S];
  logic               cn   [0:S];
  aarm_pkg::axis_t    cax  [0:S];
  aarm_pkg::axis_t    cay  [0:S];
  aarm_pkg::axis_t    caz  [0:S];

  logic               v1;
  logic signed [19:0] c1;
  logic signed [19:0] s1;
  logic signed [19:0] t1;
  logic signed [18:0] xx1, yy1, zz1, xy1, xz1, yz1;
  aarm_pkg::axis_t    x1, y1, z1;

  logic               v2;
  logic signed [38:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [37:0] pxs, pys, pzs;
  logic signed [19:0] c2;

  logic               v3;
  aarm_pkg::mat_t     m3;

  aarm_pkg::cw_t      cr_c;
  aarm_pkg::cw_t      cr_s;
  logic signed [19:0] c_n;
  logic signed [19:0] s_n;
  logic signed [39:0] diag;

  function automatic logic signed [18:0] rnd_axis(input aarm_pkg::axis_t a,
                                                  input aarm_pkg::axis_t b);
    logic signed [36:0] p;
    logic signed [36:0] q;
    p = 37'(a) * 37'(b);
    q = (p + 37'sd32768) >>> aarm_pkg::FRAC_BITS;
    return q[18:0];
  endfunction

  function automatic aarm_pkg::elem_t finish(input logic signed [39:0] sum);
    logic signed [40:0] q;
    logic signed [24:0] r;
    aarm_pkg::elem_t    e;
    q = (41'(sum) + 41'sd32768) >>> aarm_pkg::FRAC_BITS;
    r = q[24:0];
    if (r > aarm_pkg::OUT_MAX) begin
      e = aarm_pkg::OUT_MAX[18:0];
    end else if (r < aarm_pkg::OUT_MIN) begin
      e = aarm_pkg::OUT_MIN[18:0];
    end else begin
      e = r[18:0];
    end
    return e;
  endfunction

  assign adv       = !(v3 && out_full);
  assign in_take   = adv && in_valid;
  assign out_valid = v3;
  assign out_item  = m3;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0]  <= aarm_pkg::GAIN_W;
      cy[0]  <= '0;
      cz[0]  <= in_item.ang;
      cn[0]  <= in_item.neg;
      cax[0] <= in_item.ax;
      cay[0] <= in_item.ay;
      caz[0] <= in_item.az;
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_rot
    localparam aarm_pkg::cw_t ATAN = aarm_pkg::atan_w(5'(k));
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else if (adv) begin
        cv[k+1] <= cv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cz[k][33]) begin
          cx[k+1] <= cx[k] - (cy[k] >>> k);
          cy[k+1] <= cy[k] + (cx[k] >>> k);
          cz[k+1] <= cz[k] - ATAN;
        end else begin
          cx[k+1] <= cx[k] + (cy[k] >>> k);
          cy[k+1] <= cy[k] - (cx[k] >>> k);
          cz[k+1] <= cz[k] + ATAN;
        end
        cn[k+1]  <= cn[k];
        cax[k+1] <= cax[k];
        cay[k+1] <= cay[k];
        caz[k+1] <= caz[k];
      end
    end
  end

  always_comb begin
    cr_c = (cx[S] + 34'sd8192) >>> aarm_pkg::WIDEN_SHIFT;
    cr_s = (cy[S] + 34'sd8192) >>> aarm_pkg::WIDEN_SHIFT;
    c_n  = cn[S] ? -cr_c[19:0] : cr_c[19:0];
    s_n  = cn[S] ? -cr_s[19:0] : cr_s[19:0];
    diag = 40'(c2) <<< aarm_pkg::FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= cv[S];
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1  <= c_n;
      s1  <= s_n;
      t1  <= aarm_pkg::ONE_C - c_n;
      xx1 <= rnd_axis(cax[S], cax[S]);
      yy1 <= rnd_axis(cay[S], cay[S]);
      zz1 <= rnd_axis(caz[S], caz[S]);
      xy1 <= rnd_axis(cax[S], cay[S]);
      xz1 <= rnd_axis(cax[S], caz[S]);
      yz1 <= rnd_axis(cay[S], caz[S]);
      x1  <= cax[S];
      y1  <= cay[S];
      z1  <= caz[S];

      pxx <= 39'(xx1) * 39'(t1);
      pyy <= 39'(yy1) * 39'(t1);
      pzz <= 39'(zz1) * 39'(t1);
      pxy <= 39'(xy1) * 39'(t1);
      pxz <= 39'(xz1) * 39'(t1);
      pyz <= 39'(yz1) * 39'(t1);
      pxs <= 38'(x1) * 38'(s1);
      pys <= 38'(y1) * 38'(s1);
      pzs <= 38'(z1) * 38'(s1);
      c2  <= c1;

      m3.m00 <= finish(40'(pxx) + diag);
      m3.m01 <= finish(40'(pxy) + 40'(pzs));
      m3.m02 <= finish(40'(pxz) - 40'(pys));
      m3.m10 <= finish(40'(pxy) - 40'(pzs));
      m3.m11 <= finish(40'(pyy) + diag);
      m3.m12 <= finish(40'(pyz) + 40'(pxs));
      m3.m20 <= finish(40'(pxz) + 40'(pys));
      m3.m21 <= finish(40'(pyz) - 40'(pxs));
      m3.m22 <= finish(40'(pzz) + diag);
    end
  end

endmodule

FILE: rtl/axis_angle_rotation_matrix.sv
// axis_angle_rotation_matrix: top level; front reduces the angle, a short
// queue decouples it from the CORDIC and matrix back end, results leave
// through an output queue. Depends on aarm_pkg, aarm_fifo, aarm_front, aarm_back.
//
//   channel  | ports                          | handshake
//   input    | angle, axis_x, axis_y, axis_z  | push / full
//   result   | m00 .. m22                     | pop / empty
//
// one item per cycle sustained while results are popped; the path runs through
// the five remainder stages, the CORDIC rotations and three matrix stages
// rst clears all valid flags and queue pointers; payload registers are not reset
// a full output queue stalls the back end, which then fills the middle queue
// and stalls the front, which raises full
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic signed [23:0]   angle,
  input  logic signed [17:0]   axis_x,
  input  logic signed [17:0]   axis_y,
  input  logic signed [17:0]   axis_z,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [18:0]   m00,
  output logic signed [18:0]   m01,
  output logic signed [18:0]   m02,
  output logic signed [18:0]   m10,
  output logic signed [18:0]   m11,
  output logic signed [18:0]   m12,
  output logic signed [18:0]   m20,
  output logic signed [18:0]   m21,
  output logic signed [18:0]   m22
);

  localparam int WW = $bits(aarm_pkg::work_t);
  localparam int MW = $bits(aarm_pkg::mat_t);

  logic            in_ready;
  logic            f_valid;
  logic            mid_full;
  aarm_pkg::work_t f_item;
  logic            mid_empty;
  logic [WW-1:0]   mid_dout;
  aarm_pkg::work_t b_item;
  logic            b_take;
  logic            b_valid;
  logic            out_full;
  aarm_pkg::mat_t  b_mat;
  logic [MW-1:0]   out_dout;
  aarm_pkg::mat_t  res;

  assign full   = !in_ready;
  assign b_item = aarm_pkg::work_t'(mid_dout);
  assign res    = aarm_pkg::mat_t'(out_dout);
  assign m00 = res.m00;
  assign m01 = res.m01;
  assign m02 = res.m02;
  assign m10 = res.m10;
  assign m11 = res.m11;
  assign m12 = res.m12;
  assign m20 = res.m20;
  assign m21 = res.m21;
  assign m22 = res.m22;

  aarm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (in_ready),
    .angle     (angle),
    .axis_x    (axis_x),
    .axis_y    (axis_y),
    .axis_z    (axis_z),
    .out_valid (f_valid),
    .out_full  (mid_full),
    .out_item  (f_item)
  );

  aarm_fifo #(.WIDTH(WW), .DEPTH(4)) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .full  (mid_full),
    .din   (f_item),
    .pop   (b_take),
    .empty (mid_empty),
    .dout  (mid_dout)
  );

  aarm_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!mid_empty),
    .in_take   (b_take),
    .in_item   (b_item),
    .out_valid (b_valid),
    .out_full  (out_full),
    .out_item  (b_mat)
  );

  aarm_fifo #(.WIDTH(MW), .DEPTH(2)) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (b_valid),
    .full  (out_full),
    .din   (b_mat),
    .pop   (pop),
    .empty (empty),
    .dout  (out_dout)
  );

endmodule

FILE: verif/testbench.sv
// testbench: checks the axis-angle rotation matrix block against a bit-exact
// predictor of angle reduction, cordic and matrix rounding; uses aarm_pkg types
module testbench;

  localparam int LATENCY = 40;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 530;

  logic clk, rst, push, full, empty, pop;
  logic signed [23:0] angle;
  aarm_pkg::axis_t axis_x, axis_y, axis_z;
  aarm_pkg::elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

  axis_angle_rotation_matrix u_top (.*);

  typedef struct {
    logic signed [23:0] ang;
    aarm_pkg::axis_t x, y, z;
    bit has_exp;
    aarm_pkg::mat_t exp_m;
  } stim_t;

  aarm_pkg::mat_t expected_q[$];
  stim_t stim_q[$];
  int errors = 0;
  int idle_count = 0;
  int n_pushed = 0, n_popped = 0;
  int send_idle = 37, recv_idle = 66;
  bit hold_off = 0;
  bit done_sending = 0;

  localparam longint ATAN[24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic aarm_pkg::elem_t narrow_sat(longint sum);
    longint r;
    r = rnd_shift(sum, 16);
    if (r > 262143) r = 262143;
    if (r < -262144) r = -262144;
    return aarm_pkg::elem_t'(r);
  endfunction

  function automatic aarm_pkg::mat_t rotation_matrix(logic signed [23:0] ang,
                                                     aarm_pkg::axis_t ix,
                                                     aarm_pkg::axis_t iy,
                                                     aarm_pkg::axis_t iz);
    longint a, x, y, z, cx, cy, cz, nx, c, s, t, xx, yy, zz, xy, xz, yz;
    bit neg;
    aarm_pkg::mat_t m;
    a = longint'(ang) * 16384;
    x = clamp_one(ix); y = clamp_one(iy); z = clamp_one(iz);
    neg = 0;
    a = a % 64'sd6746518852;
    if (a >= 64'sd3373259426) a -= 64'sd6746518852;
    if (a < -64'sd3373259426) a += 64'sd6746518852;
    if (a > 64'sd1686629713) begin
      a -= 64'sd3373259426; neg = 1;
    end else if (a < -64'sd1686629713) begin
      a += 64'sd3373259426; neg = 1;
    end
    cx = 64'h26DD3B6A; cy = 0; cz = a;
    for (int i = 0; i < 16; i++) begin
      if (cz >= 0) begin
        nx = cx - (cy >>> i); cy = cy + (cx >>> i); cz -= ATAN[i];
      end else begin
        nx = cx + (cy >>> i); cy = cy - (cx >>> i); cz += ATAN[i];
      end
      cx = nx;
    end
    c = rnd_shift(cx, 14); s = rnd_shift(cy, 14);
    if (neg) begin
      c = -c; s = -s;
    end
    t = 65536 - c;
    xx = rnd_shift(x * x, 16); yy = rnd_shift(y * y, 16); zz = rnd_shift(z * z, 16);
    xy = rnd_shift(x * y, 16); xz = rnd_shift(x * z, 16); yz = rnd_shift(y * z, 16);
    m.m00 = narrow_sat(xx * t + c * 65536);
    m.m01 = narrow_sat(xy * t + z * s);
    m.m02 = narrow_sat(xz * t - y * s);
    m.m10 = narrow_sat(xy * t - z * s);
    m.m11 = narrow_sat(yy * t + c * 65536);
    m.m12 = narrow_sat(yz * t + x * s);
    m.m20 = narrow_sat(xz * t + y * s);
    m.m21 = narrow_sat(yz * t - x * s);
    m.m22 = narrow_sat(zz * t + c * 65536);
    return m;
  endfunction

  function automatic stim_t row(logic signed [23:0] ang, aarm_pkg::axis_t x,
                                aarm_pkg::axis_t y, aarm_pkg::axis_t z);
    stim_t r;
    r.ang = ang; r.x = x; r.y = y; r.z = z; r.has_exp = 0; r.exp_m = '0;
    return r;
  endfunction

  function automatic stim_t row_exp(logic signed [23:0] ang, aarm_pkg::axis_t x,
                                    aarm_pkg::axis_t y, aarm_pkg::axis_t z,
                                    aarm_pkg::mat_t e);
    stim_t r;
    r = row(ang, x, y, z); r.has_exp = 1; r.exp_m = e;
    return r;
  endfunction

  function automatic aarm_pkg::axis_t rand_axis();
    case ($urandom_range(0, 3))
      0: return aarm_pkg::axis_t'($urandom_range(0, 131071 * 2 + 1) - 131072);
      1: return $urandom_range(0, 1) ? aarm_pkg::AXIS_ONE : -aarm_pkg::AXIS_ONE;
      default: return aarm_pkg::axis_t'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // sender
  initial begin
    stim_t s;
    logic signed [23:0] ang;
    rst = 1; push = 0;
    angle = '0; axis_x = '0; axis_y = '0; axis_z = '0;
    // zero angle with zero axis gives identity diagonal of c = 1
    stim_q.push_back(row_exp(0, 0, 0, 0, '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536}));
    stim_q.push_back(row(0, aarm_pkg::AXIS_ONE, 0, 0));
    stim_q.push_back(row(24'sh7FFFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF));
    stim_q.push_back(row(-24'sh800000, -18'sh20000, -18'sh20000, -18'sh20000));
    stim_q.push_back(row(24'sd102944, 0, 0, aarm_pkg::AXIS_ONE));
    stim_q.push_back(row(-24'sd102944, 0, aarm_pkg::AXIS_ONE, 0));
    stim_q.push_back(row(24'sd205887, aarm_pkg::AXIS_ONE, aarm_pkg::AXIS_ONE,
                         aarm_pkg::AXIS_ONE));
    stim_q.push_back(row(-24'sd205887, -aarm_pkg::AXIS_ONE, aarm_pkg::AXIS_ONE,
                         -aarm_pkg::AXIS_ONE));
    stim_q.push_back(row(24'sd205888, 18'sd40000, -18'sd30000, 18'sd20000));
    stim_q.push_back(row(24'sd411775, 18'sd65537, -18'sd65537, 0));
    stim_q.push_back(row(24'sd411774, 18'sd1, 18'sh3FFFF, 18'sd12345));
    stim_q.push_back(row(24'sd102943, 18'sd46341, 18'sd46341, 0));
    stim_q.push_back(row(-24'sd102945, 0, 18'sd46341, -18'sd46341));
    stim_q.push_back(row(24'sd1, -aarm_pkg::AXIS_ONE, -aarm_pkg::AXIS_ONE,
                         -aarm_pkg::AXIS_ONE));
    stim_q.push_back(row(-24'sd1, 18'sh1FFFF, 0, -18'sh20000));
    stim_q.push_back(row(24'sd2000000, 18'sd30000, 18'sd30000, 18'sd30000));
    stim_q.push_back(row(24'sh555555, 18'sh15555, 18'sh2AAAA, 18'sh0AAAA));
    stim_q.push_back(row(24'shAAAAAA, 18'sh2AAAA, 18'sh15555, 18'sh35555));
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 3) == 0) ang = 24'($urandom);
      else ang = 24'(int'($urandom_range(0, 823550)) - 411775);
      stim_q.push_back(row(ang, rand_axis(), rand_axis(), rand_axis()));
    end
    repeat (3) @(posedge clk);
    rst <= 0;
    for (int k = 0; k < stim_q.size(); k++) begin
      s = stim_q[k];
      if (k == stim_q.size() / 3) begin
        send_idle = 66; recv_idle = 37;
      end
      if (k == 2 * stim_q.size() / 3) begin
        send_idle = 0; recv_idle = 0;
      end
      while ($urandom_range(0, 99) < send_idle) begin
        push <= 0;
        @(posedge clk);
      end
      push <= 1;
      angle <= s.ang; axis_x <= s.x; axis_y <= s.y; axis_z <= s.z;
      @(posedge clk);
      while (full) @(posedge clk);
      expected_q.push_back(s.has_exp ? s.exp_m : rotation_matrix(s.ang, s.x, s.y, s.z));
      n_pushed++;
    end
    push <= 0;
    done_sending = 1;
  end

  // long receiver stall so the pipeline fills and pushes back
  initial begin
    wait (n_pushed >= 40);
    hold_off = 1;
    repeat (120) @(posedge clk);
    hold_off = 0;
  end

  // receiver and checker
  always @(posedge clk) begin
    aarm_pkg::mat_t e;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (m00 !== e.m00) begin $error("m00 exp %0d got %0d", e.m00, m00); errors++; end
        if (m01 !== e.m01) begin $error("m01 exp %0d got %0d", e.m01, m01); errors++; end
        if (m02 !== e.m02) begin $error("m02 exp %0d got %0d", e.m02, m02); errors++; end
        if (m10 !== e.m10) begin $error("m10 exp %0d got %0d", e.m10, m10); errors++; end
        if (m11 !== e.m11) begin $error("m11 exp %0d got %0d", e.m11, m11); errors++; end
        if (m12 !== e.m12) begin $error("m12 exp %0d got %0d", e.m12, m12); errors++; end
        if (m20 !== e.m20) begin $error("m20 exp %0d got %0d", e.m20, m20); errors++; end
        if (m21 !== e.m21) begin $error("m21 exp %0d got %0d", e.m21, m21); errors++; end
        if (m22 !== e.m22) begin $error("m22 exp %0d got %0d", e.m22, m22); errors++; end
      end
      n_popped++;
    end
    pop <= !rst && !hold_off && ($urandom_range(0, 99) >= recv_idle);
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    wait (done_sending);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d results missing", expected_q.size());
    end
    $display("%0d items sent, %0d results checked, extremes and long stall included",
             n_pushed, n_popped);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
